// File: hw/rtl/suffix_automaton_matcher_defines.svh
// assertion macros for the suffix automaton matcher checker
// no dependencies; included by the checker file only
`ifndef SUFFIX_AUTOMATON_MATCHER_DEFINES_SVH
`define SUFFIX_AUTOMATON_MATCHER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SAM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sam check failed");

// next-cycle implication, disabled during reset
`define SAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sam check failed");

`endif

// File: hw/rtl/sam_pkg.sv
// shared operation codes and status struct for the suffix automaton matcher
// no dependencies
`default_nettype none

package sam_pkg;

   localparam int OUT_W = 12;
   localparam logic [OUT_W-1:0] OUT_MAX = 12'hFFF;

   typedef enum logic [2:0] {
      OP_CLEAR   = 3'd0,
      OP_APPEND  = 3'd1,
      OP_END     = 3'd2,
      OP_RESTART = 3'd3,
      OP_MATCH   = 3'd4
   } op_type;

   typedef struct packed {
      logic [OUT_W-1:0] match_length;
      logic             whole_prefix_matched;
      logic [OUT_W-1:0] states_used;
      logic             overflow;
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/suffix_automaton_matcher.sv
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  req_operation, req_symbol
// rsp      out  rsp_valid/rsp_stall  match length, whole prefix, states used, overflow
//
// end string, restart, unused codes and dropped or ignored appends go straight to the result
// clear: writes the root row; reset runs the same root row pass first
// match: reads the transition and follows suffix links; an out-of-range symbol skips the walk
// append: writes a new row, then probes states along the suffix link walk; a hit transition is checked
// clone: copies the row, rewrites links and probes states while redirecting
// req_stall is high until the result is loaded; one stalled result waits in the output register
// depends on sam_pkg and sam_rsp_reg
`default_nettype none

module suffix_automaton_matcher
   import sam_pkg::*;
#(
   parameter int MAX_STATES    = 4096,
   parameter int ALPHABET_SIZE = 26
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [2:0]       req_operation,
   input  wire logic [4:0]       req_symbol,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [OUT_W-1:0]      rsp_match_length,
   output logic                  rsp_whole_prefix_matched,
   output logic [OUT_W-1:0]      rsp_states_used,
   output logic                  rsp_overflow
);

   localparam int SW  = $clog2(MAX_STATES);
   localparam int CW  = $clog2(ALPHABET_SIZE);
   localparam int TAW = SW + CW;
   localparam int TD  = MAX_STATES << CW;
   localparam logic [CW-1:0] COL_LAST = CW'(ALPHABET_SIZE - 1);
   localparam logic [SW:0]   NONE     = (SW+1)'(MAX_STATES);
   localparam logic [SW+1:0] CAP_LIM  = (SW+2)'(MAX_STATES - 1);

   typedef enum logic [14:0] {
      ST_IDLE   = 15'b000000000000001,
      ST_ZERO   = 15'b000000000000010,
      ST_NEWROW = 15'b000000000000100,
      ST_W_RD   = 15'b000000000001000,
      ST_W_CHK  = 15'b000000000010000,
      ST_L_CHK  = 15'b000000000100000,
      ST_LK_Q   = 15'b000000001000000,
      ST_LK_NP  = 15'b000000010000000,
      ST_CP     = 15'b000000100000000,
      ST_CP_END = 15'b000001000000000,
      ST_W2_RD  = 15'b000010000000000,
      ST_W2_CHK = 15'b000100000000000,
      ST_M_RD   = 15'b001000000000000,
      ST_M_CHK  = 15'b010000000000000,
      ST_FIN    = 15'b100000000000000
   } state_type;

   state_type      st_ff, st_in;
   logic [SW-1:0]  cnt_ff, cnt_in;
   logic [SW-1:0]  acur_ff, acur_in;
   logic [SW-1:0]  mcur_ff, mcur_in;
   logic [SW-1:0]  cur_ff, cur_in;
   logic [SW:0]    smat_ff, smat_in;
   logic           ovf_ff, ovf_in;
   logic [SW:0]    p_ff, p_in;
   logic [SW-1:0]  np_ff, np_in;
   logic [SW-1:0]  q_ff, q_in;
   logic [SW-1:0]  cl_ff, cl_in;
   logic [SW-1:0]  lenp_ff, lenp_in;
   logic [SW-1:0]  lnp_ff, lnp_in;
   logic [CW-1:0]  c_ff, c_in;
   logic [CW-1:0]  col_ff, col_in;
   logic           first_ff, first_in;
   logic           emit_ff, emit_in;

   // state memories: transitions, and suffix link with length per state
   logic [SW-1:0]  trans_mem [TD];
   logic [2*SW:0]  node_mem  [MAX_STATES];
   logic [SW-1:0]  trans_rd_ff;
   logic [2*SW:0]  node_rd_ff;
   logic [SW:0]    link_rd;
   logic [SW-1:0]  len_rd;

   logic           tr_we, tr_re, nd_we, nd_re;
   logic [TAW-1:0] tr_wa, tr_ra;
   logic [SW-1:0]  tr_wd;
   logic [SW-1:0]  nd_wa, nd_ra;
   logic [2*SW:0]  nd_wd;

   logic           accept, sym_ok, rsp_busy, rsp_load;
   logic [CW-1:0]  sym_col;
   logic [SW-1:0]  p_idx;
   logic [SW+12:0] cur_ext, cnt_ext;
   status_type     status;

   assign req_stall = (st_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign sym_ok    = (9'(req_symbol) < 9'(ALPHABET_SIZE));
   assign sym_col   = CW'(req_symbol);
   assign p_idx     = p_ff[SW-1:0];
   assign rsp_load  = (st_ff == ST_FIN) && !rsp_busy;
   assign link_rd   = node_rd_ff[2*SW:SW];
   assign len_rd    = node_rd_ff[SW-1:0];

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      acur_in  = acur_ff;
      mcur_in  = mcur_ff;
      cur_in   = cur_ff;
      smat_in  = smat_ff;
      ovf_in   = ovf_ff;
      p_in     = p_ff;
      np_in    = np_ff;
      q_in     = q_ff;
      cl_in    = cl_ff;
      lenp_in  = lenp_ff;
      lnp_in   = lnp_ff;
      c_in     = c_ff;
      col_in   = col_ff;
      first_in = first_ff;
      emit_in  = emit_ff;
      tr_we = 1'b0; tr_wa = '0; tr_wd = '0;
      tr_re = 1'b0; tr_ra = {p_idx, c_ff};
      nd_we = 1'b0; nd_wa = '0; nd_wd = '0;
      nd_re = 1'b0; nd_ra = p_idx;

      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               st_in = ST_FIN;
               unique case (req_operation)
                  OP_CLEAR: begin
                     cnt_in  = '0;
                     acur_in = '0;
                     mcur_in = '0;
                     cur_in  = '0;
                     smat_in = '0;
                     ovf_in  = 1'b0;
                     col_in  = '0;
                     emit_in = 1'b1;
                     st_in   = ST_ZERO;
                  end
                  OP_APPEND: begin
                     if (sym_ok) begin
                        if ((SW+2)'(cnt_ff) + (SW+2)'(2) > CAP_LIM) begin
                           ovf_in = 1'b1;
                        end else begin
                           np_in  = cnt_ff + 1'b1;
                           cnt_in = cnt_ff + 1'b1;
                           p_in   = {1'b0, acur_ff};
                           c_in   = sym_col;
                           col_in = '0;
                           nd_re  = 1'b1;
                           nd_ra  = acur_ff;
                           st_in  = ST_NEWROW;
                        end
                     end
                  end
                  OP_END: begin
                     acur_in = '0;
                  end
                  OP_RESTART: begin
                     mcur_in = '0;
                     cur_in  = '0;
                     smat_in = '0;
                  end
                  OP_MATCH: begin
                     if (smat_ff < NONE) begin
                        smat_in = smat_ff + 1'b1;
                     end
                     if (sym_ok) begin
                        p_in     = {1'b0, mcur_ff};
                        c_in     = sym_col;
                        first_in = 1'b1;
                        st_in    = ST_M_RD;
                     end else begin
                        mcur_in = '0;
                        cur_in  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ZERO: begin
            tr_we = 1'b1;
            tr_wa = {SW'(0), col_ff};
            if (col_ff == '0) begin
               nd_we = 1'b1;
               nd_wa = '0;
               nd_wd = {NONE, {SW{1'b0}}};
            end
            col_in = col_ff + 1'b1;
            if (col_ff == COL_LAST) begin
               col_in  = '0;
               emit_in = 1'b0;
               st_in   = emit_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_NEWROW: begin
            tr_we  = 1'b1;
            tr_wa  = {np_ff, col_ff};
            col_in = col_ff + 1'b1;
            if (col_ff == COL_LAST) begin
               col_in = '0;
               lnp_in = len_rd + 1'b1;
               st_in  = ST_W_RD;
            end
         end
         ST_W_RD: begin
            tr_re = 1'b1;
            nd_re = 1'b1;
            st_in = ST_W_CHK;
         end
         ST_W_CHK: begin
            if (trans_rd_ff == '0) begin
               tr_we = 1'b1;
               tr_wa = {p_idx, c_ff};
               tr_wd = np_ff;
               p_in  = link_rd;
               if (link_rd == NONE) begin
                  nd_we   = 1'b1;
                  nd_wa   = np_ff;
                  nd_wd   = {{(SW+1){1'b0}}, lnp_ff};
                  acur_in = np_ff;
                  st_in   = ST_FIN;
               end else begin
                  st_in = ST_W_RD;
               end
            end else begin
               q_in    = trans_rd_ff;
               lenp_in = len_rd;
               nd_re   = 1'b1;
               nd_ra   = trans_rd_ff;
               st_in   = ST_L_CHK;
            end
         end
         ST_L_CHK: begin
            if (lenp_ff + 1'b1 == len_rd) begin
               nd_we   = 1'b1;
               nd_wa   = np_ff;
               nd_wd   = {{1'b0, q_ff}, lnp_ff};
               acur_in = np_ff;
               st_in   = ST_FIN;
            end else begin
               // clone q into a fresh state
               cl_in  = cnt_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
               nd_we  = 1'b1;
               nd_wa  = cnt_ff + 1'b1;
               nd_wd  = {link_rd, lenp_ff + 1'b1};
               st_in  = ST_LK_Q;
            end
         end
         ST_LK_Q: begin
            // length of q still sits in the read register
            nd_we = 1'b1;
            nd_wa = q_ff;
            nd_wd = {{1'b0, cl_ff}, len_rd};
            st_in = ST_LK_NP;
         end
         ST_LK_NP: begin
            nd_we  = 1'b1;
            nd_wa  = np_ff;
            nd_wd  = {{1'b0, cl_ff}, lnp_ff};
            col_in = '0;
            st_in  = ST_CP;
         end
         ST_CP: begin
            // read column col of q, write the column read last cycle into cl
            tr_re = 1'b1;
            tr_ra = {q_ff, col_ff};
            if (col_ff != '0) begin
               tr_we = 1'b1;
               tr_wa = {cl_ff, col_ff - 1'b1};
               tr_wd = trans_rd_ff;
            end
            col_in = col_ff + 1'b1;
            if (col_ff == COL_LAST) begin
               col_in = '0;
               st_in  = ST_CP_END;
            end
         end
         ST_CP_END: begin
            tr_we = 1'b1;
            tr_wa = {cl_ff, COL_LAST};
            tr_wd = trans_rd_ff;
            st_in = ST_W2_RD;
         end
         ST_W2_RD: begin
            tr_re = 1'b1;
            nd_re = 1'b1;
            st_in = ST_W2_CHK;
         end
         ST_W2_CHK: begin
            if (trans_rd_ff == q_ff) begin
               tr_we = 1'b1;
               tr_wa = {p_idx, c_ff};
               tr_wd = cl_ff;
               p_in  = link_rd;
               if (link_rd == NONE) begin
                  acur_in = np_ff;
                  st_in   = ST_FIN;
               end else begin
                  st_in = ST_W2_RD;
               end
            end else begin
               acur_in = np_ff;
               st_in   = ST_FIN;
            end
         end
         ST_M_RD: begin
            tr_re = 1'b1;
            nd_re = 1'b1;
            st_in = ST_M_CHK;
         end
         ST_M_CHK: begin
            if (trans_rd_ff != '0) begin
               cur_in  = first_ff ? (cur_ff + 1'b1) : (len_rd + 1'b1);
               mcur_in = trans_rd_ff;
               st_in   = ST_FIN;
            end else if (link_rd == NONE) begin
               mcur_in = '0;
               cur_in  = '0;
               st_in   = ST_FIN;
            end else begin
               p_in     = link_rd;
               first_in = 1'b0;
               st_in    = ST_M_RD;
            end
         end
         ST_FIN: begin
            if (!rsp_busy) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_ZERO;
         cnt_ff   <= '0;
         acur_ff  <= '0;
         mcur_ff  <= '0;
         cur_ff   <= '0;
         smat_ff  <= '0;
         ovf_ff   <= 1'b0;
         col_ff   <= '0;
         first_ff <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         cnt_ff   <= cnt_in;
         acur_ff  <= acur_in;
         mcur_ff  <= mcur_in;
         cur_ff   <= cur_in;
         smat_ff  <= smat_in;
         ovf_ff   <= ovf_in;
         col_ff   <= col_in;
         first_ff <= first_in;
         emit_ff  <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      np_ff   <= np_in;
      q_ff    <= q_in;
      cl_ff   <= cl_in;
      lenp_ff <= lenp_in;
      lnp_ff  <= lnp_in;
      c_ff    <= c_in;
   end

   always_ff @(posedge clock) begin
      if (tr_we) begin
         trans_mem[tr_wa] <= tr_wd;
      end
      if (tr_re) begin
         trans_rd_ff <= trans_mem[tr_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (nd_we) begin
         node_mem[nd_wa] <= nd_wd;
      end
      if (nd_re) begin
         node_rd_ff <= node_mem[nd_ra];
      end
   end

   // status as it stands after the transaction
   assign cur_ext = (SW+13)'(cur_ff);
   assign cnt_ext = (SW+13)'(cnt_ff);

   always_comb begin
      status.match_length = (cur_ext > (SW+13)'(OUT_MAX)) ? OUT_MAX : cur_ext[OUT_W-1:0];
      status.whole_prefix_matched = ({1'b0, cur_ff} == smat_ff);
      status.states_used = cnt_ext[OUT_W-1:0];
      status.overflow = ovf_ff;
   end

   sam_rsp_reg u_rsp (
      .clock                    (clock),
      .reset                    (reset),
      .load                     (rsp_load),
      .status                   (status),
      .busy                     (rsp_busy),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_match_length         (rsp_match_length),
      .rsp_whole_prefix_matched (rsp_whole_prefix_matched),
      .rsp_states_used          (rsp_states_used),
      .rsp_overflow             (rsp_overflow)
   );

endmodule

`default_nettype wire

// File: hw/rtl/sam_rsp_reg.sv
// output register of the result channel, holds a transaction while stalled
// depends on sam_pkg for status_type
`default_nettype none

module sam_rsp_reg
   import sam_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire status_type       status,
   output logic                  busy,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [OUT_W-1:0]      rsp_match_length,
   output logic                  rsp_whole_prefix_matched,
   output logic [OUT_W-1:0]      rsp_states_used,
   output logic                  rsp_overflow
);

   logic       valid_ff, valid_in;
   status_type data_ff;

   assign busy = valid_ff && rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= status;
      end
   end

   assign rsp_valid                = valid_ff;
   assign rsp_match_length         = data_ff.match_length;
   assign rsp_whole_prefix_matched = data_ff.whole_prefix_matched;
   assign rsp_states_used          = data_ff.states_used;
   assign rsp_overflow             = data_ff.overflow;

endmodule

`default_nettype wire

// File: hw/rtl/sam_checker.sv
// port-level checks of the suffix automaton matcher, bound to the top level
// depends on suffix_automaton_matcher_defines.svh and sam_pkg
`default_nettype none
`include "suffix_automaton_matcher_defines.svh"

module sam_checker
   import sam_pkg::*;
#(
   parameter int MAX_STATES = 4096
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic [2:0]       req_operation,
   input wire logic [4:0]       req_symbol,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [OUT_W-1:0] rsp_match_length,
   input wire logic             rsp_whole_prefix_matched,
   input wire logic [OUT_W-1:0] rsp_states_used,
   input wire logic             rsp_overflow
);

   logic small_cap;
   assign small_cap = (MAX_STATES <= 4096);

   // a held result stays offered
   `SAM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a held result keeps its payload
   `SAM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
      $stable({rsp_match_length, rsp_whole_prefix_matched, rsp_states_used, rsp_overflow}))

   // every accepted request raises req_stall in the cycle after
   `SAM_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall)

   // overflow is only reported once the state pool is nearly full
   `SAM_ASSERT_NOW(a_ovf_full, clock, reset, rsp_valid && rsp_overflow && small_cap,
      rsp_states_used >= OUT_W'(MAX_STATES - 2))

   // a stalled request stays offered unchanged
   `SAM_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_operation) && $stable(req_symbol))

endmodule

bind suffix_automaton_matcher sam_checker #(.MAX_STATES(MAX_STATES)) u_sam_checker (.*);

`default_nettype wire
